### rtl/bf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants and types of the 3x3 bilateral filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int RANGE_SIGMA_DEF = 3000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_WEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_WEIGHT = 2'd3;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [16:0] EDGE_RESET   = 17'd54000;
    localparam logic [16:0] CORNER_RESET = 17'd44000;
    localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

    typedef struct packed {
        logic       weight;
        logic       product;
        logic       total;
        logic       div;
        logic [2:0] bit_idx;
    } lane_ctrl_t;

endpackage

### rtl/bf3_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_line_buf
// Two line memories holding the two previous rows of packed RGB words.
// ----------------------------------------------------------------------------
module bf3_line_buf #(
    parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [23:0]                  wr_top,
    input  logic [23:0]                  wr_mid,
    output logic [23:0]                  rd_top,
    output logic [23:0]                  rd_mid
);

    logic [23:0] top_mem [MAX_WIDTH];
    logic [23:0] mid_mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_top <= top_mem[rd_addr];
            rd_mid <= mid_mem[rd_addr];
        end
        if (wr_en) begin
            top_mem[wr_addr] <= wr_top;
            mid_mem[wr_addr] <= wr_mid;
        end
    end

endmodule

### rtl/bf3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_lane
// One color channel: neighbor weights, weighted sums and a bit-serial divider.
// ----------------------------------------------------------------------------
module bf3_lane #(
    parameter int RANGE_SIGMA_X100 = bf3_pkg::RANGE_SIGMA_DEF
) (
    input  logic                aclk,
    input  bf3_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]          pix [9],
    input  logic [16:0]         edge_w,
    input  logic [16:0]         corner_w,
    output logic [7:0]          quot
);

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned Sig = longint'(RANGE_SIGMA_X100);
    localparam longint unsigned Den = 2 * Sig * Sig;

    function automatic longint unsigned exp_neg(input longint unsigned f);
        longint          sum;
        longint unsigned term;
        sum  = longint'(Q30);
        term = Q30;
        for (longint unsigned K = 1; K <= 17; K++) begin
            term = ((term * f) >> 30) / K;
            if (K[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return longint'(sum);
    endfunction

    function automatic logic [255:0][15:0] build_rom();
        logic [255:0][15:0] rom;
        longint unsigned    e1, x, n, r, v;
        e1 = exp_neg(Q30);
        for (longint unsigned d = 0; d < 256; d++) begin
            x = (d * d * 10000 * Q30) / Den;
            n = x >> 30;
            if (n >= 24) begin
                rom[d] = 16'd0;
            end else begin
                r = exp_neg(x & (Q30 - 1));
                for (longint unsigned i = 0; i < n; i++) begin
                    r = (r * e1) >> 30;
                end
                v = (r * 65536 + (Q30 >> 1)) >> 30;
                if (v > 65535) begin
                    v = 65535;
                end
                rom[d] = v[15:0];
            end
        end
        return rom;
    endfunction

    localparam logic [255:0][15:0] RangeRom = build_rom();

    logic [16:0] w_reg [9];
    logic [24:0] p_reg [9];
    logic [20:0] wsum_reg;
    logic [27:0] rem_reg;
    logic [7:0]  q_reg;

    logic [16:0] w_next [9];
    logic [20:0] wsum_next;
    logic [27:0] acc_next;
    logic [27:0] trial;

    always_comb begin
        logic [7:0]  diff;
        logic [16:0] sw;
        logic [32:0] prod;
        for (int i = 0; i < 9; i++) begin
            diff = (pix[i] > pix[4]) ? pix[i] - pix[4] : pix[4] - pix[i];
            sw   = (i == 0 || i == 2 || i == 6 || i == 8) ? corner_w : edge_w;
            prod = sw * {1'b0, RangeRom[diff]};
            w_next[i] = (i == 4) ? bf3_pkg::WEIGHT_ONE : prod[32:16];
        end
    end

    always_comb begin
        wsum_next = '0;
        acc_next  = '0;
        for (int i = 0; i < 9; i++) begin
            wsum_next = wsum_next + 21'(w_reg[i]);
            acc_next  = acc_next + 28'(p_reg[i]);
        end
        trial = 28'({7'd0, wsum_reg} << ctrl.bit_idx);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.weight) begin
            w_reg <= w_next;
        end
        if (ctrl.product) begin
            for (int i = 0; i < 9; i++) begin
                p_reg[i] <= w_reg[i] * pix[i];
            end
            wsum_reg <= wsum_next;
        end
        if (ctrl.total) begin
            rem_reg <= acc_next;
            q_reg   <= '0;
        end else if (ctrl.div && rem_reg >= trial) begin
            rem_reg             <= rem_reg - trial;
            q_reg[ctrl.bit_idx] <= 1'b1;
        end
    end

    assign quot = q_reg;

endmodule

### rtl/bilateral_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilateral_filter_3x3
// Streaming 3x3 bilateral filter on RGB frames, three channel lanes.
// ----------------------------------------------------------------------------
//  Channel  Handshake          Payload
//  s_       s_valid/s_ready    s_pix_red/green/blue, s_frame_start
//  m_       m_valid/m_ready    m_out_red/green/blue, m_out_row/col, m_frame_done
//  cfg_     cfg_wr_en          cfg_index, cfg_wr_data
//
//  A border pixel passes through the line memory read, then the window update.
//  An interior pixel passes through read, weight, product, sum, eight
//  divider steps and the output load.
//  A new word is accepted while a finished result waits on m_ready.
//  Reset is synchronous; the line memories are not cleared.
module bilateral_filter_3x3 #(
    parameter int MAX_WIDTH        = bf3_pkg::MAX_WIDTH_DEF,
    parameter int RANGE_SIGMA_X100 = bf3_pkg::RANGE_SIGMA_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_pix_red,
    input  logic [7:0]                       s_pix_green,
    input  logic [7:0]                       s_pix_blue,
    input  logic                             s_frame_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_red,
    output logic [7:0]                       m_out_green,
    output logic [7:0]                       m_out_blue,
    output logic [15:0]                      m_out_row,
    output logic [10:0]                      m_out_col,
    output logic                             m_frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WW > 12) ? WW : 12;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_WEIGHT, ST_PROD, ST_SUM, ST_DIV, ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [16:0] edge_reg, corner_reg;
    logic [CW-1:0] col_count_reg;
    logic [15:0] row_count_reg;
    logic [CW-1:0] c_reg;
    logic [15:0] r_reg;
    logic [23:0] pix_reg;
    logic [23:0] win_reg [6];
    logic [23:0] cwin_reg [9];
    logic [2:0]  bit_reg;
    logic        done_reg;
    logic        m_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [15:0] row_out_reg;
    logic [10:0] col_out_reg;
    logic        fdone_reg;

    logic          accept;
    logic          out_load;
    logic [CW-1:0] c_cur;
    logic [15:0]   r_cur;
    logic [23:0]   rd_top, rd_mid;
    logic [WCW-1:0] wcl;
    logic [15:0]   hcl;
    logic [16:0]   edge_sat, corner_sat;
    logic          produce;
    logic [31:0]   col_m1;
    bf3_pkg::lane_ctrl_t lane_ctrl;
    logic [7:0]    pix_r [9], pix_g [9], pix_b [9];
    logic [7:0]    q_r, q_g, q_b;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign c_cur = s_frame_start ? '0 : col_count_reg;
    assign r_cur = s_frame_start ? '0 : row_count_reg;

    always_comb begin
        if (WCW'(width_reg) < WCW'(3)) begin
            wcl = WCW'(3);
        end else if (WCW'(width_reg) > WCW'(MAX_WIDTH)) begin
            wcl = WCW'(MAX_WIDTH);
        end else begin
            wcl = WCW'(width_reg);
        end
        hcl        = (height_reg < 16'd3) ? 16'd3 : height_reg;
        edge_sat   = (edge_reg > bf3_pkg::WEIGHT_ONE) ? bf3_pkg::WEIGHT_ONE : edge_reg;
        corner_sat = (corner_reg > bf3_pkg::WEIGHT_ONE) ? bf3_pkg::WEIGHT_ONE : corner_reg;
        produce    = (r_reg >= 16'd2) && (32'(c_reg) >= 32'd2);
        col_m1     = 32'(c_reg) - 32'd1;
    end

    bf3_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (c_reg),
        .wr_top  (rd_mid),
        .wr_mid  (pix_reg),
        .rd_top  (rd_top),
        .rd_mid  (rd_mid)
    );

    always_comb begin
        lane_ctrl.weight  = (state_reg == ST_WEIGHT);
        lane_ctrl.product = (state_reg == ST_PROD);
        lane_ctrl.total   = (state_reg == ST_SUM);
        lane_ctrl.div     = (state_reg == ST_DIV);
        lane_ctrl.bit_idx = bit_reg;
        for (int i = 0; i < 9; i++) begin
            pix_r[i] = cwin_reg[i][7:0];
            pix_g[i] = cwin_reg[i][15:8];
            pix_b[i] = cwin_reg[i][23:16];
        end
    end

    bf3_lane #(.RANGE_SIGMA_X100(RANGE_SIGMA_X100)) u_lane_r (
        .aclk(aclk), .ctrl(lane_ctrl), .pix(pix_r),
        .edge_w(edge_sat), .corner_w(corner_sat), .quot(q_r)
    );
    bf3_lane #(.RANGE_SIGMA_X100(RANGE_SIGMA_X100)) u_lane_g (
        .aclk(aclk), .ctrl(lane_ctrl), .pix(pix_g),
        .edge_w(edge_sat), .corner_w(corner_sat), .quot(q_g)
    );
    bf3_lane #(.RANGE_SIGMA_X100(RANGE_SIGMA_X100)) u_lane_b (
        .aclk(aclk), .ctrl(lane_ctrl), .pix(pix_b),
        .edge_w(edge_sat), .corner_w(corner_sat), .quot(q_b)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = produce ? ST_WEIGHT : ST_IDLE;
            ST_WEIGHT: state_next = ST_PROD;
            ST_PROD:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIV;
            ST_DIV:    if (bit_reg == 3'd0) state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= bf3_pkg::WIDTH_RESET;
            height_reg    <= bf3_pkg::HEIGHT_RESET;
            edge_reg      <= bf3_pkg::EDGE_RESET;
            corner_reg    <= bf3_pkg::CORNER_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
            m_valid_reg   <= 1'b0;
            bit_reg       <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    bf3_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_wr_data[11:0];
                    bf3_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_wr_data[15:0];
                    bf3_pkg::REG_EDGE_WEIGHT:   edge_reg   <= cfg_wr_data;
                    bf3_pkg::REG_CORNER_WEIGHT: corner_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        c_reg   <= c_cur;
                        r_reg   <= r_cur;
                        pix_reg <= {s_pix_blue, s_pix_green, s_pix_red};
                    end
                end
                ST_READ: begin
                    for (int i = 0; i < 6; i++) begin
                        cwin_reg[i] <= win_reg[i];
                    end
                    cwin_reg[6] <= rd_top;
                    cwin_reg[7] <= rd_mid;
                    cwin_reg[8] <= pix_reg;
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= rd_top;
                    win_reg[4] <= rd_mid;
                    win_reg[5] <= pix_reg;
                    done_reg <= (r_reg == hcl - 16'd1) &&
                                (WCW'(c_reg) == wcl - WCW'(1));
                    if (WCW'(c_reg) + WCW'(1) >= wcl) begin
                        col_count_reg <= '0;
                        row_count_reg <= (17'(r_reg) + 17'd1 >= 17'(hcl)) ?
                                         16'd0 : r_reg + 16'd1;
                    end else begin
                        col_count_reg <= c_reg + CW'(1);
                        row_count_reg <= r_reg;
                    end
                end
                ST_SUM: begin
                    bit_reg <= 3'd7;
                end
                ST_DIV: begin
                    bit_reg <= bit_reg - 3'd1;
                end
                ST_OUT: begin
                    if (out_load) begin
                        red_reg     <= q_r;
                        green_reg   <= q_g;
                        blue_reg    <= q_b;
                        row_out_reg <= r_reg - 16'd1;
                        col_out_reg <= col_m1[10:0];
                        fdone_reg   <= done_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = red_reg;
    assign m_out_green  = green_reg;
    assign m_out_blue   = blue_reg;
    assign m_out_row    = row_out_reg;
    assign m_out_col    = col_out_reg;
    assign m_frame_done = fdone_reg;

`ifndef NO_ASSERTIONS
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside the output state");
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_count_reg) < MAX_WIDTH)
        else $error("column counter beyond line memory");
    a_row_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> row_out_reg != 16'd0)
        else $error("result word on border row");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !s_ready)
        else $error("input accepted during division");
`endif

endmodule
